[rtl/kmrs_pkg.sv]
// ----------------------------------------------------------------------------
// kmrs_pkg
// Shared types and constants for the k-mer read screening block.
// ----------------------------------------------------------------------------
package kmrs_pkg;

  // default sizing
  localparam int MAX_K_DEF      = 9;
  localparam int COUNT_BITS_DEF = 32;

  // fixed field widths
  localparam int KIND_W    = 2;
  localparam int BASE_W    = 2;
  localparam int KLEN_W    = 4;
  localparam int OUT_CNT_W = 32;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd9;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_REF   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  // one finished-read result
  typedef struct packed {
    logic                 matched;
    logic [OUT_CNT_W-1:0] seen;
    logic [OUT_CNT_W-1:0] hits;
  } result_t;

endpackage

[rtl/kmrs_in_if.sv]
// ----------------------------------------------------------------------------
// kmrs_in_if
// Input channel: reference bases, read bases and empty read markers.
// ----------------------------------------------------------------------------
interface kmrs_in_if;
  import kmrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BASE_W-1:0] base;
  logic              last;

  modport source (output valid, output kind, output base, output last, input ready);
  modport sink   (input valid, input kind, input base, input last, output ready);
endinterface

[rtl/kmrs_out_if.sv]
// ----------------------------------------------------------------------------
// kmrs_out_if
// Result channel: match flag and running read counts per finished read.
// ----------------------------------------------------------------------------
interface kmrs_out_if;
  import kmrs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 read_matched;
  logic [OUT_CNT_W-1:0] reads_seen;
  logic [OUT_CNT_W-1:0] reads_matched;

  modport source (output valid, output read_matched, output reads_seen,
                  output reads_matched, input ready);
  modport sink   (input valid, input read_matched, input reads_seen,
                  input reads_matched, output ready);
endinterface

[rtl/kmrs_ram.sv]
// ----------------------------------------------------------------------------
// kmrs_ram
// Generic single-write, single-read synchronous RAM with registered read.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module kmrs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

[rtl/kmer_read_screen_core.sv]
// ----------------------------------------------------------------------------
// kmer_read_screen_core
// K-mer presence screening: reference windows set bits in a presence bitmap,
// read windows look them up, and each finished read reports a match flag.
// ----------------------------------------------------------------------------
// latency: a result is registered in the lookup stage, then in the result queue, before it is presented
// throughput: one item per cycle while results drain; set by the single read
//   port of the bitmap RAM, with write-back forwarded to a following access
// reset: synchronous; the bitmap is swept clear one row per cycle, all
//   2**(2*MAX_K-6) rows for MAX_K > 3 (4096 at MAX_K = 9), with in ready low meanwhile
module kmer_read_screen_core #(
  parameter int MAX_K      = kmrs_pkg::MAX_K_DEF,
  parameter int COUNT_BITS = kmrs_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [kmrs_pkg::KLEN_W-1:0] cfg_wdata,
  kmrs_in_if.sink                     in_ch,
  kmrs_out_if.source                  out_ch
);
  import kmrs_pkg::*;

  localparam int IDX_W  = 2 * MAX_K;
  localparam int COL_W  = (IDX_W > 6) ? 6 : IDX_W - 1;
  localparam int ROW_W  = IDX_W - COL_W;
  localparam int RAM_WD = 1 << COL_W;
  localparam int RAM_DP = 1 << ROW_W;
  localparam int FILL_W = $clog2(MAX_K + 1);

  // configuration register
  logic [KLEN_W-1:0] klen_r;
  logic [KLEN_W-1:0] eff_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= KLEN_RESET;
    end else if (cfg_we) begin
      klen_r <= cfg_wdata;
    end
  end

  // effective window length, clamped to 1..MAX_K
  always_comb begin
    priority if (klen_r == '0) begin
      eff_k = KLEN_W'(1);
    end else if (klen_r > KLEN_W'(MAX_K)) begin
      eff_k = KLEN_W'(MAX_K);
    end else begin
      eff_k = klen_r;
    end
  end

  // bitmap clearing sweep after reset
  logic             clr_r;
  logic [ROW_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == '1) begin
        clr_r <= 1'b0;
      end
    end
  end

  // output queue, two entries
  result_t    q_r [2];
  logic [1:0] q_cnt_r;
  logic       pop;
  logic       push;
  logic       slot_full;
  result_t    res_b;

  // access stage signals
  logic              in_fire;
  logic              b_res;
  logic [2:0]        credit_used;
  logic [2:0]        credit_cap;

  // lookup stage registers
  logic              b_valid_r;
  logic [KIND_W-1:0] b_kind_r;
  logic              b_last_r;
  logic              b_look_r;
  logic [ROW_W-1:0]  b_row_r;
  logic [COL_W-1:0]  b_col_r;
  logic              fwd_r;
  logic [RAM_WD-1:0] fwd_data_r;

  // a result is pending in the lookup stage for empty markers and read ends
  assign b_res = b_valid_r && ((b_kind_r == KIND_EMPTY) ||
                               ((b_kind_r == KIND_READ) && b_last_r));

  // take an item only when its result is sure to find room in the queue
  assign pop         = out_ch.valid && out_ch.ready;
  assign credit_used = {1'b0, q_cnt_r} + {2'b00, b_res};
  assign credit_cap  = 3'd2 + {2'b00, pop};
  assign in_ch.ready = !clr_r && (credit_used < credit_cap);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // sliding window of bases
  logic [IDX_W-1:0]        win_r;
  logic [FILL_W-1:0]       fill_r;
  logic [IDX_W+BASE_W-1:0] win_cat;
  logic [IDX_W-1:0]        win_nxt;
  logic [FILL_W-1:0]       fill_nxt;
  logic [IDX_W-1:0]        kmask;
  logic [IDX_W-1:0]        kidx;
  logic                    a_seq;
  logic                    a_look;

  assign win_cat  = {win_r, in_ch.base};
  assign win_nxt  = win_cat[IDX_W-1:0];
  assign fill_nxt = (fill_r < FILL_W'(MAX_K)) ? fill_r + 1'b1 : fill_r;
  assign a_seq    = (in_ch.kind == KIND_REF) || (in_ch.kind == KIND_READ);
  assign a_look   = a_seq && (KLEN_W'(fill_nxt) >= eff_k);

  // keep the low 2k bits of the window as the k-mer index
  always_comb begin
    for (int j = 0; j < IDX_W; j++) begin
      kmask[j] = (5'(j) < {eff_k, 1'b0});
    end
  end

  assign kidx = win_nxt & kmask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      fill_r <= '0;
    end else if (in_fire) begin
      if (a_seq) begin
        win_r  <= in_ch.last ? '0 : win_nxt;
        fill_r <= in_ch.last ? '0 : fill_nxt;
      end else if (in_ch.kind == KIND_EMPTY) begin
        win_r  <= '0;
        fill_r <= '0;
      end
    end
  end

  // bitmap RAM, one bit per k-mer, rows of RAM_WD bits
  logic              ram_we;
  logic [ROW_W-1:0]  ram_waddr;
  logic [RAM_WD-1:0] ram_wdata;
  logic [RAM_WD-1:0] ram_rdata;
  logic [RAM_WD-1:0] row_b;
  logic              set_b;
  logic              hit_now;

  kmrs_ram #(
    .WIDTH (RAM_WD),
    .DEPTH (RAM_DP)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (kidx[IDX_W-1:COL_W]),
    .rdata (ram_rdata)
  );

  // row as seen by the lookup stage, including a write from the cycle before
  assign row_b   = fwd_r ? fwd_data_r : ram_rdata;
  assign set_b   = b_valid_r && b_look_r && (b_kind_r == KIND_REF);
  assign hit_now = b_look_r && row_b[b_col_r];

  // write-back of a reference bit, or zero rows during the sweep
  always_comb begin
    if (clr_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = set_b;
      ram_waddr = b_row_r;
      ram_wdata = row_b | (RAM_WD'(1) << b_col_r);
    end
  end

  // lookup stage pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      b_valid_r <= in_fire;
      fwd_r     <= in_fire && set_b && (b_row_r == kidx[IDX_W-1:COL_W]);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= ram_wdata;
    if (in_fire) begin
      b_kind_r <= in_ch.kind;
      b_last_r <= in_ch.last;
      b_look_r <= a_look;
      b_row_r  <= kidx[IDX_W-1:COL_W];
      b_col_r  <= kidx[COL_W-1:0];
    end
  end

  // hit flag and running counts
  logic                  hit_r;
  logic [COUNT_BITS-1:0] read_cnt_r;
  logic [COUNT_BITS-1:0] match_cnt_r;
  logic [COUNT_BITS-1:0] read_cnt_nxt;
  logic [COUNT_BITS-1:0] match_cnt_nxt;
  logic                  matched_b;

  assign matched_b     = (b_kind_r == KIND_READ) && (hit_r || hit_now);
  assign read_cnt_nxt  = (read_cnt_r != '1) ? read_cnt_r + 1'b1 : read_cnt_r;
  assign match_cnt_nxt = (matched_b && (match_cnt_r != '1)) ?
                         match_cnt_r + 1'b1 : match_cnt_r;
  assign push          = b_res;

  always_comb begin
    res_b.matched = matched_b;
    res_b.seen    = OUT_CNT_W'(read_cnt_nxt);
    res_b.hits    = OUT_CNT_W'(match_cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= 1'b0;
      read_cnt_r  <= '0;
      match_cnt_r <= '0;
    end else if (b_valid_r) begin
      unique case (b_kind_r)
        KIND_REF: begin
          if (b_last_r) begin
            hit_r <= 1'b0;
          end
        end
        KIND_READ: begin
          hit_r <= b_last_r ? 1'b0 : (hit_r || hit_now);
        end
        KIND_EMPTY: begin
          hit_r <= 1'b0;
        end
        default: begin
        end
      endcase
      if (push) begin
        read_cnt_r  <= read_cnt_nxt;
        match_cnt_r <= match_cnt_nxt;
      end
    end
  end

  // result queue, a pushed item lands in slot 1 only behind a held entry
  assign slot_full = q_cnt_r[1] || (q_cnt_r[0] && !pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && !slot_full) begin
      q_r[0] <= res_b;
    end else if (pop) begin
      q_r[0] <= q_r[1];
    end
    if (push && slot_full) begin
      q_r[1] <= res_b;
    end
  end

  assign out_ch.valid         = (q_cnt_r != '0);
  assign out_ch.read_matched  = q_r[0].matched;
  assign out_ch.reads_seen    = q_r[0].seen;
  assign out_ch.reads_matched = q_r[0].hits;

  // checks
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (q_cnt_r != 2'd2))
    else $error("result queue overflow");

  a_no_sweep_collision: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !b_valid_r)
    else $error("item in lookup stage during bitmap sweep");

  a_match_le_reads: assert property (@(posedge clk) disable iff (!rst_n)
    match_cnt_r <= read_cnt_r)
    else $error("match count exceeds read count");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_K))
    else $error("window fill beyond MAX_K");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the k-mer read screening core against an in-bench predictor: a
// directed opener, then phases at different k-mer lengths whose reads are
// mostly copied from earlier reference bases, with random idling on both
// channels and a cycle watchdog.
// ----------------------------------------------------------------------------
import kmrs_pkg::*;

// predicts every finished-read result and checks the block's results in order
class read_screen_scoreboard;
  bit                   presence[];
  bit [2*MAX_K_DEF-1:0] window;
  int unsigned          fill;
  bit                   hit;
  bit [OUT_CNT_W-1:0]   read_total;
  bit [OUT_CNT_W-1:0]   match_total;
  bit [KLEN_W-1:0]      kmer_length;
  result_t              expected_q[$];
  int unsigned          errors;

  function new();
    presence    = new[1 << (2*MAX_K_DEF)];
    kmer_length = KLEN_RESET;
  endfunction

  function void set_kmer_length(bit [KLEN_W-1:0] value);
    kmer_length = value;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // window ends with every sequence end and every empty read marker
  function void end_sequence();
    window = '0;
    fill   = 0;
    hit    = 1'b0;
  endfunction

  function void finish_read(bit matched);
    if (read_total != '1) read_total++;
    if (matched && match_total != '1) match_total++;
    expected_q.push_back(result_t'{matched, read_total, match_total});
  endfunction

  // one accepted input item
  function void note_item(kind_t kind, bit [1:0] base, bit last);
    int unsigned k;
    int unsigned mask;
    bit [2*MAX_K_DEF-1:0] key;
    bit matched;
    if (kind == KIND_RSVD) return;
    if (kind == KIND_EMPTY) begin
      end_sequence();
      finish_read(1'b0);
      return;
    end
    // zero acts as one, anything above the maximum as the maximum
    k = (kmer_length == 0) ? 1 : (kmer_length > MAX_K_DEF) ? MAX_K_DEF : kmer_length;
    window = {window[2*MAX_K_DEF-3:0], base};
    if (fill < MAX_K_DEF) fill++;
    if (fill >= k) begin
      mask = (32'd1 << (2*k)) - 1;
      key  = window & mask[2*MAX_K_DEF-1:0];
      if (kind == KIND_REF) presence[key] = 1'b1;
      else if (presence[key]) hit = 1'b1;
    end
    if (!last) return;
    matched = hit;
    end_sequence();
    if (kind == KIND_READ) finish_read(matched);
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual matched=%0b seen=%0d hits=%0d",
               $time, got.matched, got.seen, got.hits);
      return;
    end
    want = expected_q.pop_front();
    if (got.matched !== want.matched) begin
      errors++;
      $display("%0t: read_matched expected %0b actual %0b", $time, want.matched, got.matched);
    end
    if (got.seen !== want.seen) begin
      errors++;
      $display("%0t: reads_seen expected %0d actual %0d", $time, want.seen, got.seen);
    end
    if (got.hits !== want.hits) begin
      errors++;
      $display("%0t: reads_matched expected %0d actual %0d", $time, want.hits, got.hits);
    end
  endfunction
endclass

module testbench;
  localparam int IDLE_LIMIT     = 20000;
  localparam int ITEMS_PER_STEP = 82;
  localparam int N_PHASES       = 9;
  localparam int REF_KEEP       = 512;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [KLEN_W-1:0] cfg_wdata;

  kmrs_in_if  in_ch();
  kmrs_out_if out_ch();

  read_screen_scoreboard sb;
  bit          quiet;
  int unsigned items_sent;
  int unsigned idle_cycles;
  int unsigned ready_stall;
  bit [1:0]    ref_bases[$];

  // lengths per phase: out-of-range zero and fifteen, both legal extremes
  bit [KLEN_W-1:0] klen_plan[N_PHASES] = '{4'd0, 4'd1, 4'd15, 4'd3, 4'd9,
                                           4'd5, 4'd2, 4'd12, 4'd7};

  kmer_read_screen_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #6 clk = ~clk;

  // result side: random stall bursts, none once quiet
  always @(negedge clk) begin
    if (!quiet && ready_stall > 0) begin
      ready_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) ready_stall = $urandom_range(1, 14);
    end
  end

  // check each accepted result
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(result_t'{out_ch.read_matched, out_ch.reads_seen, out_ch.reads_matched});
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // present one item, optionally after a gap, and hold it until accepted
  task automatic send_item(kind_t kind, bit [1:0] base, bit last);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.base  <= base;
    in_ch.last  <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(kind, base, last);
    if (kind != KIND_RSVD) items_sent++;
    if (kind == KIND_REF) begin
      ref_bases.push_back(base);
      if (ref_bases.size() > REF_KEEP) void'(ref_bases.pop_front());
    end
  endtask

  // sender holds off until every expected result is back, then lets the
  // pipeline empty of items that give no result
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one phase of random sequences at a given register value
  task automatic run_phase(bit [KLEN_W-1:0] klen, int unsigned target);
    int unsigned k;
    int unsigned pick;
    int unsigned len;
    int unsigned start;
    bit [1:0]    seq[$];
    k = (klen == 0) ? 1 : (klen > MAX_K_DEF) ? MAX_K_DEF : klen;
    while (items_sent < target) begin
      seq  = {};
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // reference sequence, sometimes shorter than a window
        len = $urandom_range(1, k + 8);
        repeat (len) seq.push_back(2'($urandom_range(0, 3)));
        foreach (seq[i]) send_item(KIND_REF, seq[i], i == len - 1);
      end else if (pick < 70) begin
        // read copied from earlier reference bases, one base sometimes changed
        len = $urandom_range(k, k + 6);
        start = (ref_bases.size() > len) ? $urandom_range(0, ref_bases.size() - len) : 0;
        for (int i = 0; i < len; i++)
          seq.push_back((start + i < ref_bases.size()) ? ref_bases[start + i]
                                                      : 2'($urandom_range(0, 3)));
        if ($urandom_range(0, 2) == 0)
          seq[$urandom_range(0, len - 1)] = 2'($urandom_range(0, 3));
        foreach (seq[i]) send_item(KIND_READ, seq[i], i == len - 1);
      end else if (pick < 85) begin
        // random read, short ones included
        len = $urandom_range(1, k + 6);
        repeat (len) seq.push_back(2'($urandom_range(0, 3)));
        foreach (seq[i]) send_item(KIND_READ, seq[i], i == len - 1);
      end else if (pick < 92) begin
        // reference bases run into a read with no end marker between
        len = $urandom_range(1, k);
        repeat (len) send_item(KIND_REF, 2'($urandom_range(0, 3)), 1'b0);
        len = $urandom_range(1, k);
        for (int i = 0; i < len; i++)
          send_item(KIND_READ, 2'($urandom_range(0, 3)), i == len - 1);
      end else if (pick < 97) begin
        send_item(KIND_EMPTY, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else begin
        send_item(KIND_RSVD, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    sb           = new();
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_REF;
    in_ch.base   = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
    quiet        = 1'b0;
    items_sent   = 0;
    idle_cycles  = 0;
    ready_stall  = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // opener at the reset length: an all-T reference window sets the top key
    for (int i = 0; i < 9; i++) send_item(KIND_REF, 2'd3, i == 8);
    // reference bases then read bases with no end between share one window
    for (int i = 0; i < 4; i++) send_item(KIND_REF, 2'd3, 1'b0);
    for (int i = 0; i < 5; i++) send_item(KIND_READ, 2'd3, i == 4);
    // empty read markers with base and last both ways
    send_item(KIND_EMPTY, 2'd3, 1'b1);
    send_item(KIND_EMPTY, 2'd0, 1'b0);
    // reserved kind is dropped
    send_item(KIND_RSVD, 2'd3, 1'b1);
    // read shorter than the window
    send_item(KIND_READ, 2'd0, 1'b0);
    send_item(KIND_READ, 2'd0, 1'b1);

    // phases, each with a register write while idle; map carries over
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      if (p == N_PHASES - 1) quiet = 1'b1;
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= klen_plan[p];
      @(posedge clk);
      sb.set_kmer_length(klen_plan[p]);
      @(negedge clk);
      cfg_we <= 1'b0;
      run_phase(klen_plan[p], items_sent + ITEMS_PER_STEP);
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/kmrs_pkg.sv
rtl/kmrs_in_if.sv
rtl/kmrs_out_if.sv
rtl/kmrs_ram.sv
rtl/kmer_read_screen_core.sv
dv/testbench.sv
